[sv/linear_blend_skinning_core_assert.svh]
// Assertion macros for the linear blend skinning core.
// Include from any RTL file that asserts; no other dependencies.
`ifndef LINEAR_BLEND_SKINNING_CORE_ASSERT_SVH
`define LINEAR_BLEND_SKINNING_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define LBS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define LBS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/lbs_pkg.sv]
// Shared codes and controller/datapath interface types for the skinning core.
// No dependencies.
`default_nettype none

package lbs_pkg;

  localparam logic [2:0] KIND_LOAD_BASE = 3'd0;
  localparam logic [2:0] KIND_LOAD_BONE = 3'd1;
  localparam logic [2:0] KIND_CLEAR     = 3'd2;
  localparam logic [2:0] KIND_WEIGHT    = 3'd3;
  localparam logic [2:0] KIND_READ      = 3'd4;

  localparam logic [1:0] ATTR_POSITION = 2'd0;
  localparam logic [1:0] ROW_BASE_POS  = 2'd3;

  localparam logic [1:0] CFG_ENABLED   = 2'd0;
  localparam logic [1:0] CFG_THRESHOLD = 2'd1;

  // controller -> datapath
  typedef struct packed {
    logic       latch;     // capture vertex and weight of the accepted beat
    logic       base_we;   // write base vector row from the input beat
    logic       bone_we;   // write bone row from the input beat
    logic       acc_clr;   // zero one accumulator row, advance sweep
    logic       issue_w;   // launch one attribute into the weight pipeline
    logic       issue_r;   // read one accumulator row for read-out
    logic [1:0] attr;      // attribute of the issue or output load
    logic       out_load;  // load the output register from the read row
    logic       out_last;  // final result of this read-out
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       in_range;
    logic       wt_pass;
    logic [3:0] enabled;
    logic       pipe_busy;
    logic       out_free;
    logic       clr_last;
  } sts_t;

endpackage

`default_nettype wire

[sv/lbs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[sv/lbs_ctrl.sv]
// Sequencer for the skinning core: decodes beats, walks enabled attributes.
// Depends on lbs_pkg.
`default_nettype none

module lbs_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [2:0]    in_kind,
  output logic               in_ready,
  input  wire lbs_pkg::sts_t sts,
  output lbs_pkg::cmd_t      cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_WISSUE = 6'b000010,
    S_WDRAIN = 6'b000100,
    S_RISSUE = 6'b001000,
    S_RWAIT  = 6'b010000,
    S_CLEAR  = 6'b100000
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] mask_r, mask_nxt;
  logic [1:0] attr_r, attr_nxt;
  logic [1:0] low_attr;
  logic [3:0] mask_drop;

  function automatic logic [1:0] lowest(input logic [3:0] m);
    logic [1:0] a;
    a = 2'd3;
    if (m[2]) a = 2'd2;
    if (m[1]) a = 2'd1;
    if (m[0]) a = 2'd0;
    return a;
  endfunction

  assign low_attr  = lowest(mask_r);
  assign in_ready  = (state_r == S_IDLE);

  always_comb begin
    mask_drop = mask_r;
    mask_drop[low_attr] = 1'b0;
  end

  always_comb begin
    state_nxt = state_r;
    mask_nxt  = mask_r;
    attr_nxt  = attr_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          case (in_kind)
            lbs_pkg::KIND_LOAD_BASE: cmd.base_we = sts.in_range;
            lbs_pkg::KIND_LOAD_BONE: cmd.bone_we = 1'b1;
            lbs_pkg::KIND_CLEAR:     state_nxt = S_CLEAR;
            lbs_pkg::KIND_WEIGHT: begin
              if (sts.in_range && sts.wt_pass && (sts.enabled != 4'd0)) begin
                mask_nxt  = sts.enabled;
                state_nxt = S_WISSUE;
              end
            end
            lbs_pkg::KIND_READ: begin
              if (sts.in_range && (sts.enabled != 4'd0)) begin
                mask_nxt  = sts.enabled;
                state_nxt = S_RISSUE;
              end
            end
            default: ;
          endcase
        end
      end
      S_WISSUE: begin
        cmd.issue_w = 1'b1;
        cmd.attr    = low_attr;
        mask_nxt    = mask_drop;
        if (mask_drop == 4'd0) state_nxt = S_WDRAIN;
      end
      S_WDRAIN: begin
        if (!sts.pipe_busy) state_nxt = S_IDLE;
      end
      S_RISSUE: begin
        cmd.issue_r = 1'b1;
        cmd.attr    = low_attr;
        attr_nxt    = low_attr;
        state_nxt   = S_RWAIT;
      end
      S_RWAIT: begin
        cmd.attr = attr_r;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = (mask_drop == 4'd0);
          mask_nxt     = mask_drop;
          state_nxt    = (mask_drop == 4'd0) ? S_IDLE : S_RISSUE;
        end
      end
      S_CLEAR: begin
        cmd.acc_clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mask_r  <= 4'd0;
      attr_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      mask_r  <= mask_nxt;
      attr_r  <= attr_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/lbs_dp.sv]
// Skinning datapath: config and bone registers, vertex stores, transform
// pipeline and output register. Depends on lbs_pkg and lbs_ram.
`default_nettype none

module lbs_dp #(
  parameter int VERTEX_COUNT = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic [1:0]         in_attribute,
  input  wire logic [9:0]         in_vertex_index,
  input  wire logic [1:0]         in_row,
  input  wire logic signed [31:0] in_x,
  input  wire logic signed [31:0] in_y,
  input  wire logic signed [31:0] in_z,
  input  wire logic signed [31:0] in_w,
  input  wire logic [16:0]        in_weight,
  input  wire lbs_pkg::cmd_t      cmd,
  output lbs_pkg::sts_t           sts,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_attribute_res,
  output logic [9:0]              out_vertex_index_res,
  output logic signed [31:0]      out_x,
  output logic signed [31:0]      out_y,
  output logic signed [31:0]      out_z,
  output logic                    out_last
);

  localparam int VTX_USED   = (VERTEX_COUNT < 1024) ? VERTEX_COUNT : 1024;
  localparam int SLOT_DEPTH = VTX_USED * 4;
  localparam int AW         = $clog2(SLOT_DEPTH);

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    else if (v < -64'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  // configuration and bone state
  logic [3:0]         enabled_r;
  logic [16:0]        thr_r;
  logic signed [31:0] mat_r [3][4];
  logic signed [31:0] bbp_r [3];
  logic [9:0]         vtx_r;
  logic [16:0]        weight_r;
  logic [AW-1:0]      clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 4'd0;
      thr_r     <= 17'd1;
      for (int r = 0; r < 3; r++) begin
        bbp_r[r] <= '0;
        for (int c = 0; c < 4; c++) mat_r[r][c] <= '0;
      end
    end else begin
      if (cfg_valid && (cfg_index == lbs_pkg::CFG_ENABLED)) enabled_r <= cfg_data[3:0];
      if (cfg_valid && (cfg_index == lbs_pkg::CFG_THRESHOLD)) thr_r <= cfg_data[16:0];
      if (cmd.bone_we) begin
        if (in_row == lbs_pkg::ROW_BASE_POS) begin
          bbp_r[0] <= in_x;
          bbp_r[1] <= in_y;
          bbp_r[2] <= in_z;
        end else begin
          mat_r[in_row][0] <= in_x;
          mat_r[in_row][1] <= in_y;
          mat_r[in_row][2] <= in_z;
          mat_r[in_row][3] <= in_w;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      vtx_r    <= in_vertex_index;
      weight_r <= in_weight;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_cnt_r <= '0;
    else if (cmd.latch) clr_cnt_r <= '0;
    else if (cmd.acc_clr) clr_cnt_r <= clr_cnt_r + 1'b1;
  end

  // stores: one 96-bit row per vertex and attribute, {z, y, x}
  logic [11:0]   in_slot, rd_slot, wr_slot;
  logic [95:0]   base_q, acc_q, acc_wdata;
  logic          acc_we;
  logic [AW-1:0] acc_waddr;

  assign in_slot = {in_vertex_index, in_attribute};
  assign rd_slot = {vtx_r, cmd.attr};

  lbs_ram #(.WIDTH(96), .DEPTH(SLOT_DEPTH)) u_base_ram (
    .clk   (clk),
    .we    (cmd.base_we),
    .waddr (in_slot[AW-1:0]),
    .wdata ({in_z, in_y, in_x}),
    .re    (cmd.issue_w),
    .raddr (rd_slot[AW-1:0]),
    .rdata (base_q)
  );

  lbs_ram #(.WIDTH(96), .DEPTH(SLOT_DEPTH)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .re    (cmd.issue_w || cmd.issue_r),
    .raddr (rd_slot[AW-1:0]),
    .rdata (acc_q)
  );

  // transform pipeline, one attribute per issue
  logic               v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [1:0]         a1_r, a2_r, a3_r, a4_r, a5_r;
  logic [95:0]        acc2_r, acc3_r, acc4_r, acc5_r;
  logic signed [31:0] vec2_r [3];
  logic signed [63:0] prod3_r [3][3];
  logic signed [31:0] trans3_r [3];
  logic signed [31:0] t4_r [3];
  logic signed [49:0] wp5_r [3];
  logic signed [63:0] sum4 [3];
  logic signed [31:0] acc_new [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue_w;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum4[r] = (prod3_r[r][0] >>> 16) + (prod3_r[r][1] >>> 16) + (prod3_r[r][2] >>> 16)
                + 64'(trans3_r[r]);
      acc_new[r] = sat32(64'($signed(acc5_r[r*32 +: 32])) + 64'(wp5_r[r] >>> 16));
    end
  end

  always_ff @(posedge clk) begin
    a1_r   <= cmd.attr;
    a2_r   <= a1_r;
    a3_r   <= a2_r;
    a4_r   <= a3_r;
    a5_r   <= a4_r;
    acc2_r <= acc_q;
    acc3_r <= acc2_r;
    acc4_r <= acc3_r;
    acc5_r <= acc4_r;
    for (int c = 0; c < 3; c++) begin
      // position is taken relative to the bone base
      if (a1_r == lbs_pkg::ATTR_POSITION)
        vec2_r[c] <= sat32(64'($signed(base_q[c*32 +: 32])) - 64'(bbp_r[c]));
      else
        vec2_r[c] <= $signed(base_q[c*32 +: 32]);
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) prod3_r[r][c] <= mat_r[r][c] * vec2_r[c];
      trans3_r[r] <= (a2_r == lbs_pkg::ATTR_POSITION) ? mat_r[r][3] : 32'sd0;
      t4_r[r]     <= sat32(sum4[r]);
      wp5_r[r]    <= t4_r[r] * $signed({1'b0, weight_r});
    end
  end

  assign wr_slot   = {vtx_r, a5_r};
  assign acc_we    = cmd.acc_clr || v5_r;
  assign acc_waddr = cmd.acc_clr ? clr_cnt_r : wr_slot[AW-1:0];
  assign acc_wdata = cmd.acc_clr ? 96'd0 : {acc_new[2], acc_new[1], acc_new[0]};

  // output register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_attribute_res    <= cmd.attr;
      out_vertex_index_res <= vtx_r;
      out_x                <= $signed(acc_q[31:0]);
      out_y                <= $signed(acc_q[63:32]);
      out_z                <= $signed(acc_q[95:64]);
      out_last             <= cmd.out_last;
    end
  end

  assign out_valid = out_valid_r;

  assign sts.in_range  = (32'(in_vertex_index) < VERTEX_COUNT);
  assign sts.wt_pass   = (in_weight > thr_r);
  assign sts.enabled   = enabled_r;
  assign sts.pipe_busy = v1_r || v2_r || v3_r || v4_r || v5_r;
  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.clr_last  = (clr_cnt_r == AW'(SLOT_DEPTH - 1));

endmodule

`default_nettype wire

[sv/linear_blend_skinning_core.sv]
// Linear blend skinning core, Q16.16, one bone, four attributes per vertex.
// Input beats on in_*, result beats on out_*, register writes on cfg_*.
// Kinds: load base vector, load bone row and weight update change state only;
// clear frame zeroes every accumulator row; read out returns one result beat
// per enabled attribute in attribute order, with out_last on the final one.
// Sequencing (items are handled one at a time):
//   load base, load bone, ignored kinds: done when the beat is accepted.
//   weight: the enabled attributes are issued in turn; the shared transform
//     pipeline (diff, 3x3 multiply, sum, weight multiply, accumulate) takes
//     one attribute per cycle and drains before the next beat.
//   read out: each enabled attribute is read from the registered-read accumulator
//     memory, then loaded into the output register once that is free.
//   clear frame: all 4*min(VERTEX_COUNT,1024) rows, one row swept per cycle.
// Reset zeroes the bone registers, enabled_attributes and sets the threshold
// to 1; base vectors and accumulators are undefined until written or cleared.
// A stalled receiver holds the result in the output register; the core takes
// the next input beat as soon as the last result of an item is registered.
`default_nettype none

`include "linear_blend_skinning_core_assert.svh"

module linear_blend_skinning_core #(
  parameter int VERTEX_COUNT = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_kind,
  input  wire logic [1:0]         in_attribute,
  input  wire logic [9:0]         in_vertex_index,
  input  wire logic [1:0]         in_row,
  input  wire logic signed [31:0] in_x,
  input  wire logic signed [31:0] in_y,
  input  wire logic signed [31:0] in_z,
  input  wire logic signed [31:0] in_w,
  input  wire logic [16:0]        in_weight,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_attribute_res,
  output logic [9:0]              out_vertex_index_res,
  output logic signed [31:0]      out_x,
  output logic signed [31:0]      out_y,
  output logic signed [31:0]      out_z,
  output logic                    out_last
);

  lbs_pkg::cmd_t cmd;
  lbs_pkg::sts_t sts;

  // register writes go straight into the config registers, always take them
  assign cfg_ready = 1'b1;

  lbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lbs_dp #(.VERTEX_COUNT(VERTEX_COUNT)) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_attribute         (in_attribute),
    .in_vertex_index      (in_vertex_index),
    .in_row               (in_row),
    .in_x                 (in_x),
    .in_y                 (in_y),
    .in_z                 (in_z),
    .in_w                 (in_w),
    .in_weight            (in_weight),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_attribute_res    (out_attribute_res),
    .out_vertex_index_res (out_vertex_index_res),
    .out_x                (out_x),
    .out_y                (out_y),
    .out_z                (out_z),
    .out_last             (out_last)
  );

  // a new beat must never overtake accumulator writes still in flight
  `LBS_ASSERT_IMP(a_ready_drained, clk, rst_n, in_ready, !sts.pipe_busy, "ready with pipeline busy")
  // a weight issue never coincides with a read issue or a clear write
  `LBS_ASSERT_IMP(a_one_access, clk, rst_n, cmd.issue_w, !cmd.issue_r && !cmd.acc_clr, "access clash")
  // the clear sweep runs through to its last row
  `LBS_ASSERT_NXT(a_clear_runs, clk, rst_n, cmd.acc_clr && !sts.clr_last, cmd.acc_clr, "sweep cut short")

endmodule

`default_nettype wire
